/* design/heightmap_grid_mesh_assert.svh */
// ----------------------------------------------------------------------------
// heightmap_grid_mesh assertion macros
// Shared property forms for the grid mesh checks.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_GRID_MESH_ASSERT_SVH
`define HEIGHTMAP_GRID_MESH_ASSERT_SVH

// same-cycle implication
`define HGM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HGM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/hgm_pkg.sv */
// ----------------------------------------------------------------------------
// hgm_pkg
// Types and register codes of the heightmap grid mesh block.
// ----------------------------------------------------------------------------
package hgm_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COORD_W    = 32;

   localparam logic [CSR_IDX_W-1:0] REG_LINE_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_START     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X_STEP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Y_START     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Y_STEP      = 3'd5;

   typedef struct packed {
      logic              hole;
      logic [COORD_W-1:0] height;
   } hgm_sample_type;

   // x_lstart / y_lstart are start - step, base of the left / upper vertex
   typedef struct packed {
      logic [10:0]        line_length;
      logic [15:0]        line_count;
      logic [COORD_W-1:0] x_start;
      logic [COORD_W-1:0] x_lstart;
      logic [COORD_W-1:0] y_start;
      logic [COORD_W-1:0] y_lstart;
   } hgm_cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] xh;
      logic [COORD_W-1:0] xl;
      logic [COORD_W-1:0] yh;
      logic [COORD_W-1:0] yu;
      logic [COORD_W-1:0] zh;
      logic [COORD_W-1:0] zl;
      logic [COORD_W-1:0] zu;
      logic [COORD_W-1:0] zul;
   } hgm_tri_type;

endpackage

/* design/hgm_csr.sv */
// ----------------------------------------------------------------------------
// hgm_csr
// Configuration registers; keeps start - step precomputed per axis.
// ----------------------------------------------------------------------------
module hgm_csr
   import hgm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output hgm_cfg_type           cfg
);

   hgm_cfg_type        cfg_ff, cfg_in;
   logic [COORD_W-1:0] x_step_ff, x_step_in;
   logic [COORD_W-1:0] y_step_ff, y_step_in;

   always_comb begin
      cfg_in    = cfg_ff;
      x_step_in = x_step_ff;
      y_step_in = y_step_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LINE_LENGTH: cfg_in.line_length = csr_wdata[10:0];
            REG_LINE_COUNT:  cfg_in.line_count  = csr_wdata[15:0];
            REG_X_START: begin
               cfg_in.x_start  = csr_wdata;
               cfg_in.x_lstart = csr_wdata - x_step_ff;
            end
            REG_X_STEP: begin
               x_step_in       = csr_wdata;
               cfg_in.x_lstart = cfg_ff.x_start - csr_wdata;
            end
            REG_Y_START: begin
               cfg_in.y_start  = csr_wdata;
               cfg_in.y_lstart = csr_wdata - y_step_ff;
            end
            REG_Y_STEP: begin
               y_step_in       = csr_wdata;
               cfg_in.y_lstart = cfg_ff.y_start - csr_wdata;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_length <= 11'd1024;
         cfg_ff.line_count  <= 16'd1024;
         cfg_ff.x_start     <= '0;
         cfg_ff.x_lstart    <= -32'sd65536;
         cfg_ff.y_start     <= '0;
         cfg_ff.y_lstart    <= -32'sd65536;
         x_step_ff          <= 32'd65536;
         y_step_ff          <= 32'd65536;
      end else begin
         cfg_ff    <= cfg_in;
         x_step_ff <= x_step_in;
         y_step_ff <= y_step_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/hgm_line_store.sv */
// ----------------------------------------------------------------------------
// hgm_line_store
// Previous-line sample memory, read-first, registered read data.
// ----------------------------------------------------------------------------
module hgm_line_store
   import hgm_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              access,
   input  logic [ADDR_W-1:0] addr,
   input  hgm_sample_type    wdata,
   output hgm_sample_type    rdata
);

   hgm_sample_type mem [DEPTH];
   hgm_sample_type rdata_ff;

   // old entry comes out while the new sample replaces it
   always_ff @(posedge clock) begin
      if (access) begin
         rdata_ff   <= mem[addr];
         mem[addr]  <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/hgm_tri_out.sv */
// ----------------------------------------------------------------------------
// hgm_tri_out
// Output register for one cell; sends its two triangles in turn.
// ----------------------------------------------------------------------------
module hgm_tri_out
   import hgm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  hgm_tri_type  quad,
   output logic         free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   output logic         rsp_tlast    // last_of_cell
);

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   hgm_tri_type cell_ff;

   assign free = !valid_ff || (rsp_tready && phase_ff);

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = 1'b0;
      end else if (valid_ff && rsp_tready) begin
         if (phase_ff) begin
            valid_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cell_ff <= quad;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = phase_ff;

   always_comb begin
      if (phase_ff) begin
         rsp_tdata = {cell_ff.zl, cell_ff.yh, cell_ff.xl,
                      cell_ff.zu, cell_ff.yu, cell_ff.xh,
                      cell_ff.zul, cell_ff.yu, cell_ff.xl};
      end else begin
         rsp_tdata = {cell_ff.zu, cell_ff.yu, cell_ff.xh,
                      cell_ff.zl, cell_ff.yh, cell_ff.xl,
                      cell_ff.zh, cell_ff.yh, cell_ff.xh};
      end
   end

endmodule

/* design/heightmap_grid_mesh.sv */
// A cell's first triangle passes stage 1 (memory read), stage 2 (products) and the
// output register after its request is accepted; the second follows in the cycle after
// the first is taken. Throughput: one request per cycle, but a request that closes a
// cell stalls the stream in stage 2 until the output register has sent both triangles
// of the previous cell; line store is one read-first port. Reset clears counters,
// neighbor samples and pipeline valids; the line store is not cleared, valid once written.
// ----------------------------------------------------------------------------
// heightmap_grid_mesh
// Triangulates a raster-order height grid into two triangles per valid cell.
// ----------------------------------------------------------------------------
`include "heightmap_grid_mesh_assert.svh"

module heightmap_grid_mesh
   import hgm_pkg::*;
#(
   parameter int LINE_MAX = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // height
   input  logic                  req_tuser,   // hole
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [287:0]          rsp_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   output logic                  rsp_tlast,   // last_of_cell
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(LINE_MAX);
   localparam int LEN_W = (COL_W + 1 > 11) ? COL_W + 1 : 11;

   hgm_cfg_type    cfg;
   hgm_sample_type here;
   hgm_sample_type up;
   hgm_tri_type    quad;

   logic req_go;
   logic s1_go, s2_go, s1_free, s2_free, s3_free;
   logic hgm_out_free;

   // counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0]      line_ff, line_in;
   logic [LEN_W-1:0] len_eff;
   logic [15:0]      cnt_eff;

   // stage 1: memory read in flight
   logic             s1_valid_ff, s1_valid_in;
   hgm_sample_type   s1_here_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [15:0]      s1_line_ff;

   hgm_sample_type left_ff, ul_ff;

   // stage 2: products
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_emit_ff, s2_emit_in;
   logic [COORD_W-1:0] s2_px_ff, s2_py_ff;
   logic [COORD_W-1:0] s2_zh_ff, s2_zl_ff, s2_zu_ff, s2_zul_ff;

   logic [COORD_W-1:0] u_csr_x_step, u_csr_y_step;

   hgm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign here.hole   = req_tuser;
   assign here.height = req_tdata;

   assign req_tready = s1_free;
   assign req_go     = req_tvalid && req_tready;

   hgm_line_store #(
      .DEPTH  (LINE_MAX),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock  (clock),
      .access (req_go),
      .addr   (col_ff),
      .wdata  (here),
      .rdata  (up)
   );

   // effective line length and count
   always_comb begin
      if (cfg.line_length == 11'd0) begin
         len_eff = LEN_W'(1);
      end else if (LEN_W'(cfg.line_length) > LEN_W'(LINE_MAX)) begin
         len_eff = LEN_W'(LINE_MAX);
      end else begin
         len_eff = LEN_W'(cfg.line_length);
      end
      cnt_eff = (cfg.line_count == 16'd0) ? 16'd1 : cfg.line_count;
   end

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      if (req_go) begin
         if (LEN_W'(col_ff) + LEN_W'(1) >= len_eff) begin
            col_in  = '0;
            line_in = (17'(line_ff) + 17'd1 >= 17'(cnt_eff)) ? 16'd0 : line_ff + 16'd1;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // pipeline handshake
   assign s3_free = hgm_out_free;
   assign s2_go   = s2_valid_ff && (!s2_emit_ff || s3_free);
   assign s2_free = !s2_valid_ff || s2_go;
   assign s1_go   = s1_valid_ff && s2_free;
   assign s1_free = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_go) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_go) begin
         s2_valid_in = 1'b1;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
      s2_emit_in = !s1_here_ff.hole && (s1_col_ff != '0) && (s1_line_ff != 16'd0) &&
                   !left_ff.hole && !up.hole && !ul_ff.hole;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         line_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         left_ff     <= '0;
         ul_ff       <= '0;
      end else begin
         col_ff      <= col_in;
         line_ff     <= line_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_go) begin
            left_ff <= s1_here_ff;
            ul_ff   <= up;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_here_ff <= here;
         s1_col_ff  <= col_ff;
         s1_line_ff <= line_ff;
      end
      if (s1_go) begin
         s2_emit_ff <= s2_emit_in;
         s2_px_ff   <= COORD_W'(COORD_W'(s1_col_ff) * u_csr_x_step);
         s2_py_ff   <= COORD_W'(COORD_W'(s1_line_ff) * u_csr_y_step);
         s2_zh_ff   <= s1_here_ff.height;
         s2_zl_ff   <= left_ff.height;
         s2_zu_ff   <= up.height;
         s2_zul_ff  <= ul_ff.height;
      end
   end

   // step = start - lstart, modulo 2^32
   assign u_csr_x_step = cfg.x_start - cfg.x_lstart;
   assign u_csr_y_step = cfg.y_start - cfg.y_lstart;

   always_comb begin
      quad.xh  = cfg.x_start  + s2_px_ff;
      quad.xl  = cfg.x_lstart + s2_px_ff;
      quad.yh  = cfg.y_start  + s2_py_ff;
      quad.yu  = cfg.y_lstart + s2_py_ff;
      quad.zh  = s2_zh_ff;
      quad.zl  = s2_zl_ff;
      quad.zu  = s2_zu_ff;
      quad.zul = s2_zul_ff;
   end

   hgm_tri_out u_tri_out (
      .clock      (clock),
      .reset      (reset),
      .load       (s2_go && s2_emit_ff),
      .quad       (quad),
      .free       (hgm_out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `HGM_ASSERT_NEXT(a_second_tri, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tlast,
      "second triangle of a cell missing")
   `HGM_ASSERT_SAME(a_col_range, clock, reset,
      1'b1, 32'(col_ff) < LINE_MAX, "column index beyond line store")
   `HGM_ASSERT_NEXT(a_req_to_s1, clock, reset,
      req_go, s1_valid_ff, "accepted request not held in read stage")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// heightmap_grid_mesh testbench
// Streams height samples through the grid triangulator under a range of grid
// sizes and coordinate settings, predicts every triangle in a scoreboard and
// compares each response field by field, with random gaps and backpressure.
// ----------------------------------------------------------------------------
module testbench
   import hgm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_MAX     = 1024;
   localparam int ITEM_TARGET  = 1850;
   localparam int SETTLE       = 8;
   localparam int LIMIT_CYCLES = 1000000;

   typedef struct {
      logic [8:0][31:0] word;   // a_x in word 0 up to c_z in word 8
      logic             last;
   } triangle_type;

   class mesh_scoreboard;
      logic [10:0]    line_length;
      logic [15:0]    line_count;
      logic [31:0]    x_start, x_step, y_start, y_step;
      hgm_sample_type line_store [LINE_MAX];
      bit             written [LINE_MAX];
      hgm_sample_type left_sample, upper_left_sample;
      int unsigned    column, line;
      triangle_type   expected [$];
      int unsigned    errors, checked, cells;
      string          field_name [9] = '{"a_x", "a_y", "a_z", "b_x", "b_y", "b_z",
                                         "c_x", "c_y", "c_z"};

      function new();
         line_length = 11'd1024;
         line_count  = 16'd1024;
         x_start = '0;
         x_step  = 32'h0001_0000;
         y_start = '0;
         y_step  = 32'h0001_0000;
         foreach (line_store[i]) begin
            line_store[i] = '0;
            written[i]    = 1'b0;
         end
         left_sample = '0;
         upper_left_sample = '0;
         column = 0;
         line = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            REG_LINE_LENGTH: line_length = data[10:0];
            REG_LINE_COUNT:  line_count  = data[15:0];
            REG_X_START:     x_start = data;
            REG_X_STEP:      x_step  = data;
            REG_Y_START:     y_start = data;
            REG_Y_STEP:      y_step  = data;
            default: ;
         endcase
      endfunction

      // keeps the line store read-after-write: past line 0 every column that
      // the next lines can read must already hold a sample
      function int unsigned safe_length(int unsigned want);
         int unsigned eff, need, prefix;
         eff = (want == 0) ? 1 : ((want > LINE_MAX) ? LINE_MAX : want);
         if (line == 0)
            return want;
         prefix = 0;
         while (prefix < LINE_MAX && written[prefix])
            prefix++;
         need = (eff > column + 1) ? eff : column + 1;
         if (need <= prefix)
            return want;
         return $urandom_range(1, prefix);
      endfunction

      function logic [31:0] coord(logic [31:0] base, logic [31:0] step, int unsigned idx);
         return base + step * 32'(idx);
      endfunction

      function triangle_type make_triangle(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz,
                                           logic last);
         triangle_type t;
         t.word = {cz, cy, cx, bz, by, bx, az, ay, ax};
         t.last = last;
         return t;
      endfunction

      function void note_sample(logic [31:0] height, logic hole);
         int unsigned    len, cnt;
         hgm_sample_type here, up;
         logic [31:0]    xh, xl, yh, yu;
         len = (line_length == 0) ? 1 : ((line_length > LINE_MAX) ? LINE_MAX : line_length);
         cnt = (line_count == 0) ? 1 : line_count;
         here = {hole, height};
         up = line_store[column];
         if (!here.hole && column > 0 && line > 0 && !left_sample.hole && !up.hole &&
             !upper_left_sample.hole) begin
            xh = coord(x_start, x_step, column);
            xl = coord(x_start, x_step, column - 1);
            yh = coord(y_start, y_step, line);
            yu = coord(y_start, y_step, line - 1);
            expected = {expected, make_triangle(xh, yh, here.height, xl, yh,
                                                left_sample.height, xh, yu, up.height,
                                                1'b0)};
            expected = {expected, make_triangle(xl, yu, upper_left_sample.height, xh, yu,
                                                up.height, xl, yh, left_sample.height,
                                                1'b1)};
            cells++;
         end
         upper_left_sample = up;
         left_sample = here;
         line_store[column] = here;
         written[column] = 1'b1;
         if (column + 1 >= len) begin
            column = 0;
            line = (line + 1 >= cnt) ? 0 : line + 1;
         end else begin
            column = column + 1;
         end
      endfunction

      function void check_triangle(logic [287:0] data, logic last);
         triangle_type     want;
         logic [8:0][31:0] got;
         if (expected.size() == 0) begin
            $error("triangle received with none pending");
            errors++;
            return;
         end
         want = expected.pop_front();
         got = data;
         for (int i = 0; i < 9; i++) begin
            if (got[i] !== want.word[i]) begin
               $error("%s: expected %h, got %h", field_name[i], want.word[i], got[i]);
               errors++;
            end
         end
         if (last !== want.last) begin
            $error("last_of_cell: expected %b, got %b", want.last, last);
            errors++;
         end
         checked++;
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;   // height
   logic                  req_tuser  = 1'b0; // hole
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [287:0]          rsp_tdata;         // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   logic                  rsp_tlast;         // last_of_cell
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   mesh_scoreboard sb = new();
   bit             calm;
   bit             stalled_once;
   int unsigned    samples_sent;
   int unsigned    setups;
   int unsigned    cycle_count;

   heightmap_grid_mesh #(.LINE_MAX(LINE_MAX)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic apply_config(int unsigned len, int unsigned cnt, logic [31:0] xs,
                               logic [31:0] xd, logic [31:0] ys, logic [31:0] yd);
      logic [31:0]          v [6];
      logic [CSR_IDX_W-1:0] idx [6];
      v   = '{32'(len), 32'(cnt), xs, xd, ys, yd};
      idx = '{REG_LINE_LENGTH, REG_LINE_COUNT, REG_X_START, REG_X_STEP, REG_Y_START,
              REG_Y_STEP};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= v[i];
         sb.write_reg(idx[i], v[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      setups++;
   endtask

   task automatic send_sample(logic [31:0] height, logic hole);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= height;
      req_tuser  <= hole;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(height, hole);
      samples_sent++;
   endtask

   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [31:0] dh [11] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h1234_5678, 32'h5555_AAAA,
                               32'hAAAA_5555, 32'h0F0F_F0F0};
      // 3x3 grid with wrapping coordinates, hole in the middle of the last line
      apply_config(3, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      for (int i = 0; i < 11; i++)
         send_sample(dh[i], i == 7);
      finish_phase();
      // zero length acts as one column
      apply_config(0, 4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000);
      for (int i = 0; i < 4; i++)
         send_sample(pick_value(), 1'b0);
      finish_phase();
      // zero line count acts as one line, ends on line 0
      apply_config(2, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
      for (int i = 0; i < 3; i++)
         send_sample(pick_value(), 1'b0);
      finish_phase();
   endtask

   task automatic run_full_width();
      // over-long length clamps to the full line; fills the whole line store
      calm = 1'b0;
      apply_config(sb.safe_length(2047), 2, $urandom, 32'h0001_0000, $urandom,
                   32'hFFFF_0000);
      repeat (LINE_MAX + 60)
         send_sample(pick_value(), $urandom_range(0, 99) < 5);
      finish_phase();
   endtask

   task automatic run_random_phase();
      int unsigned n, hole_pct, len, cnt, r;
      n = $urandom_range(15, 120);
      case ($urandom_range(0, 4))
         0, 1: hole_pct = 0;
         2: hole_pct = 5;
         3: hole_pct = 15;
         default: hole_pct = 40;
      endcase
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 12);
      else if (r < 85) len = $urandom_range(13, 64);
      else if (r < 90) len = 0;
      else if (r < 95) len = $urandom_range(1025, 2047);
      else             len = $urandom_range(65, 1024);
      r = $urandom_range(0, 99);
      if (r < 60)      cnt = $urandom_range(1, 6);
      else if (r < 75) cnt = 0;
      else if (r < 85) cnt = 65535;
      else             cnt = $urandom_range(7, 300);
      calm = ($urandom_range(0, 3) == 0);
      apply_config(sb.safe_length(len), cnt, pick_value(), pick_value(), pick_value(),
                   pick_value());
      repeat (n)
         send_sample(pick_value(), $urandom_range(0, 99) < hole_pct);
      finish_phase();
   endtask

   // response side: random backpressure plus one long hold-off while requests keep coming
   initial begin
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_triangle(rsp_tdata, rsp_tlast);
         if (!stalled_once && sb.checked >= 150 && req_tvalid) begin
            hold = 300;
            stalled_once = 1'b1;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
               hold = pick_gap();
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_full_width();
      while (samples_sent < ITEM_TARGET)
         run_random_phase();
      $display("Sent %0d height samples over %0d register setups.", samples_sent, setups);
      $display("Compared %0d triangles from %0d grid cells.", sb.checked, sb.cells);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
